### src/chr_pkg.sv
// chr_pkg: shared types, codes and constants for the consistent hash ring
// holds the fnv-1a fold used by the key hash and the ring point hash
// depends on nothing
package chr_pkg;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [7:0]  CHAR_HASH = 8'h23;
	localparam logic [7:0]  CHAR_ZERO = 8'h30;
	localparam logic [7:0]  VNODES_RESET = 8'd200;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_SELECT = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic        valid;
		logic [5:0]  owner;
		logic [31:0] point;
	} ring_entry_t;

	// one fnv-1a step: xor the byte, multiply by the prime modulo 2^32
	function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return x * FNV_PRIME;
	endfunction

endpackage

### src/consistent_hash_ring_unit.sv
// consistent_hash_ring_unit: fnv-1a keyed consistent hashing ring
// ring table in one synchronous memory, scanned by a single sequencer
// depends on chr_pkg
//
// Key bytes are taken one per cycle and give no result until the last byte.
// After reset every ring entry is cleared while busy is high.
// A remove or select scans the whole ring with busy high, then raises done.
// An add runs, for each of virtual_nodes copies, the hash steps (PRE, then one
// HASH step per decimal digit), one ring scan (it stops early on an equal hash)
// and one NEXT step, all bounded by the single read port of the ring memory.
// Every command with a result raises done for one cycle; the receiver
// cannot stall. busy is low while done is high, so a new beat can be taken at the edge
// that ends the done cycle.
module consistent_hash_ring_unit import chr_pkg::*; #(
	parameter int RING_SIZE = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [7:0]  key_byte,
	input  logic        last_byte,
	input  logic [5:0]  node,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output logic        done,
	output logic [1:0]  status,
	output logic [5:0]  chosen_node,
	output logic [31:0] point_hash
);

	localparam int AW = $clog2(RING_SIZE);
	localparam int SW = AW + 1;
	localparam logic [SW-1:0] RING_END = SW'(RING_SIZE);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_PRE   = 3'd3;
	localparam logic [2:0] ST_HASH  = 3'd4;
	localparam logic [2:0] ST_PLACE = 3'd5;
	localparam logic [2:0] ST_NEXT  = 3'd6;

	logic [2:0]    state_q;
	logic [7:0]    vnodes_q;
	logic [31:0]   hash_q;
	logic [1:0]    op_q;
	logic [5:0]    node_q;
	logic [SW-1:0] scan_q;
	logic [31:0]   ph_q;
	logic [7:0]    copy_q;
	logic [3:0]    d2_q, d1_q, d0_q;
	logic [1:0]    dig_q;
	logic          free_q;
	logic [AW-1:0] free_addr_q;
	logic          any_q, ge_q;
	logic [31:0]   min_q, best_q;
	logic [5:0]    own_min_q, own_best_q;

	// ring memory and its read pipeline
	ring_entry_t   mem [RING_SIZE];
	ring_entry_t   rdata_s1;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_addr_s1;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	ring_entry_t   mem_wdata;
	logic          issue;
	logic [AW-1:0] raddr;

	logic          accept;
	logic [31:0]   hash_in;
	logic          scan_end;
	logic [3:0]    digit;
	logic          hit;
	logic          result_now;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign hash_in  = fnv_fold(hash_q, key_byte);
	assign issue    = (state_q == ST_SCAN || state_q == ST_PLACE) && (scan_q < RING_END);
	assign raddr    = scan_q[AW-1:0];
	assign scan_end = (scan_q == RING_END) && !rd_vld_s1;
	assign hit      = rd_vld_s1 && rdata_s1.valid && (rdata_s1.point == ph_q);

	// decimal digit of the copy number for the current hash step
	always_comb begin
		unique case (dig_q)
			2'd2:    digit = d2_q;
			2'd1:    digit = d1_q;
			default: digit = d0_q;
		endcase
	end

	// condition for a result beat, registered into done
	always_comb begin
		unique case (state_q)
			ST_IDLE:  result_now = accept && (cmd == CMD_ADD) && last_byte && (vnodes_q == 8'd0);
			ST_SCAN:  result_now = scan_end;
			ST_PLACE: result_now = !hit && scan_end && !free_q;
			ST_NEXT:  result_now = ({1'b0, copy_q} + 9'd1 == {1'b0, vnodes_q});
			default:  result_now = 1'b0;
		endcase
	end

	// memory write selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_addr_s1;
		mem_wdata = '{valid: 1'b1, owner: node_q, point: ph_q};
		priority if (state_q == ST_CLEAR) begin
			mem_we    = (scan_q < RING_END);
			mem_waddr = scan_q[AW-1:0];
			mem_wdata = '{valid: 1'b0, owner: 6'd0, point: 32'd0};
		end else if (state_q == ST_SCAN && op_q == CMD_REMOVE) begin
			mem_we    = rd_vld_s1 && rdata_s1.valid && (rdata_s1.owner == node_q);
			mem_wdata = '{valid: 1'b0, owner: rdata_s1.owner, point: rdata_s1.point};
		end else if (state_q == ST_PLACE) begin
			if (hit) begin
				mem_we = 1'b1;
			end else if (scan_end && free_q) begin
				mem_we    = 1'b1;
				mem_waddr = free_addr_q;
			end
		end else begin
			mem_we = 1'b0;
		end
	end

	// ring memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			vnodes_q    <= VNODES_RESET;
			hash_q      <= FNV_BASIS;
			scan_q      <= '0;
			rd_vld_s1   <= 1'b0;
			done        <= 1'b0;
			op_q        <= CMD_ADD;
			node_q      <= '0;
			rd_addr_s1  <= '0;
			ph_q        <= '0;
			copy_q      <= '0;
			d2_q        <= '0;
			d1_q        <= '0;
			d0_q        <= '0;
			dig_q       <= '0;
			free_q      <= 1'b0;
			free_addr_q <= '0;
			any_q       <= 1'b0;
			ge_q        <= 1'b0;
			min_q       <= '0;
			best_q      <= '0;
			own_min_q   <= '0;
			own_best_q  <= '0;
			status      <= STATUS_OK;
			chosen_node <= '0;
			point_hash  <= '0;
		end else begin
			done       <= result_now;
			rd_vld_s1  <= issue;
			rd_addr_s1 <= raddr;
			if (issue) begin
				scan_q <= scan_q + SW'(1);
			end
			if (cfg_we) begin
				vnodes_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_CLEAR: begin
					scan_q <= scan_q + SW'(1);
					if (scan_q == RING_END) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					scan_q <= '0;
					any_q  <= 1'b0;
					ge_q   <= 1'b0;
					if (accept && cmd == CMD_REMOVE) begin
						op_q    <= cmd;
						node_q  <= node;
						state_q <= ST_SCAN;
					end else if (accept && (cmd == CMD_ADD || cmd == CMD_SELECT)) begin
						op_q   <= cmd;
						node_q <= node;
						if (last_byte && cmd == CMD_SELECT) begin
							hash_q  <= hash_in;
							state_q <= ST_SCAN;
						end else if (last_byte && vnodes_q == 8'd0) begin
							status      <= STATUS_OK;
							chosen_node <= node;
							point_hash  <= '0;
							hash_q      <= FNV_BASIS;
						end else if (last_byte) begin
							hash_q  <= hash_in;
							copy_q  <= '0;
							d2_q    <= '0;
							d1_q    <= '0;
							d0_q    <= '0;
							state_q <= ST_PRE;
						end else begin
							hash_q <= hash_in;
						end
					end
				end
				ST_SCAN: begin
					// select keeps the lowest point and the lowest at or above the key
					if (rd_vld_s1 && rdata_s1.valid && op_q == CMD_SELECT) begin
						if (!any_q || rdata_s1.point < min_q) begin
							min_q     <= rdata_s1.point;
							own_min_q <= rdata_s1.owner;
						end
						any_q <= 1'b1;
						if (rdata_s1.point >= hash_q && (!ge_q || rdata_s1.point < best_q)) begin
							best_q     <= rdata_s1.point;
							own_best_q <= rdata_s1.owner;
							ge_q       <= 1'b1;
						end
					end
					if (scan_end) begin
						state_q <= ST_IDLE;
						if (op_q == CMD_REMOVE) begin
							status      <= STATUS_OK;
							chosen_node <= node_q;
							point_hash  <= '0;
						end else begin
							hash_q <= FNV_BASIS;
							if (!any_q) begin
								status      <= STATUS_EMPTY;
								chosen_node <= '0;
								point_hash  <= '0;
							end else if (ge_q) begin
								status      <= STATUS_OK;
								chosen_node <= own_best_q;
								point_hash  <= best_q;
							end else begin
								status      <= STATUS_OK;
								chosen_node <= own_min_q;
								point_hash  <= min_q;
							end
						end
					end
				end
				ST_PRE: begin
					// start the point hash with the separator
					ph_q    <= fnv_fold(hash_q, CHAR_HASH);
					state_q <= ST_HASH;
					if (d2_q != 4'd0) begin
						dig_q <= 2'd2;
					end else if (d1_q != 4'd0) begin
						dig_q <= 2'd1;
					end else begin
						dig_q <= 2'd0;
					end
				end
				ST_HASH: begin
					ph_q <= fnv_fold(ph_q, CHAR_ZERO + {4'd0, digit});
					if (dig_q == 2'd0) begin
						scan_q  <= '0;
						free_q  <= 1'b0;
						state_q <= ST_PLACE;
					end else begin
						dig_q <= dig_q - 2'd1;
					end
				end
				ST_PLACE: begin
					if (hit) begin
						state_q <= ST_NEXT;
					end else if (scan_end) begin
						if (free_q) begin
							state_q <= ST_NEXT;
						end else begin
							status      <= STATUS_FULL;
							chosen_node <= node_q;
							point_hash  <= ph_q;
							hash_q      <= FNV_BASIS;
							state_q     <= ST_IDLE;
						end
					end else if (rd_vld_s1 && !rdata_s1.valid && !free_q) begin
						free_q      <= 1'b1;
						free_addr_q <= rd_addr_s1;
					end
				end
				ST_NEXT: begin
					// bcd count of the copy number
					if ({1'b0, copy_q} + 9'd1 == {1'b0, vnodes_q}) begin
						status      <= STATUS_OK;
						chosen_node <= node_q;
						point_hash  <= ph_q;
						hash_q      <= FNV_BASIS;
						state_q     <= ST_IDLE;
					end else begin
						copy_q  <= copy_q + 8'd1;
						state_q <= ST_PRE;
						if (d0_q != 4'd9) begin
							d0_q <= d0_q + 4'd1;
						end else begin
							d0_q <= 4'd0;
							if (d1_q != 4'd9) begin
								d1_q <= d1_q + 4'd1;
							end else begin
								d1_q <= 4'd0;
								d2_q <= d2_q + 4'd1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
